/* sv/multiword_by_digit_divider_unit_assert.svh */
// Assertion macros for the divider RTL.
`ifndef MULTIWORD_BY_DIGIT_DIVIDER_UNIT_ASSERT_SVH
`define MULTIWORD_BY_DIGIT_DIVIDER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked property check, disabled while reset is asserted.
`define MBDD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mbdd assertion failed");
// Expression that must never be true.
`define MBDD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `MBDD_ASSERT(lbl, clk, rstn, !(expr))
`else
`define MBDD_ASSERT(lbl, clk, rstn, prop)
`define MBDD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* sv/mbdd_pkg.sv */
// Types, microcode and constants for the multiword by digit divider.
package mbdd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PC_W   = 3;

  typedef struct packed {
    logic [WORD_W-1:0] dividend_digit;
    logic              final_digit;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] quotient_digit;
    logic [WORD_W-1:0] remainder_out;
    logic              end_of_number;
    logic              divide_by_zero;
  } out_word_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_PRE,
    OP_DIG,
    OP_ITER,
    OP_EMIT
  } op_e;

  // branch conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_DZ,
    C_LT,
    C_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    op_e  op;
    logic go;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic dz;
    logic lt;
    logic more;
  } status_t;

  // program step addresses
  localparam logic [PC_W-1:0] STEP_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] STEP_ZCHK   = 3'd1;
  localparam logic [PC_W-1:0] STEP_RCHK   = 3'd2;
  localparam logic [PC_W-1:0] STEP_PRE    = 3'd3;
  localparam logic [PC_W-1:0] STEP_RLOOP  = 3'd4;
  localparam logic [PC_W-1:0] STEP_DIG    = 3'd5;
  localparam logic [PC_W-1:0] STEP_DLOOP  = 3'd6;
  localparam logic [PC_W-1:0] STEP_EMIT   = 3'd7;

  // Control store. The step after STEP_EMIT wraps to STEP_WAIT.
  function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: STEP_WAIT};
    case (pc)
      STEP_WAIT:  w = '{op: OP_ACCEPT, cond: C_NO_INPUT, target: STEP_WAIT};
      STEP_ZCHK:  w = '{op: OP_NOP,    cond: C_DZ,       target: STEP_EMIT};
      STEP_RCHK:  w = '{op: OP_NOP,    cond: C_LT,       target: STEP_DIG};
      STEP_PRE:   w = '{op: OP_PRE,    cond: C_NEVER,    target: STEP_WAIT};
      STEP_RLOOP: w = '{op: OP_ITER,   cond: C_MORE,     target: STEP_RLOOP};
      STEP_DIG:   w = '{op: OP_DIG,    cond: C_NEVER,    target: STEP_WAIT};
      STEP_DLOOP: w = '{op: OP_ITER,   cond: C_MORE,     target: STEP_DLOOP};
      STEP_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: STEP_EMIT};
      default:    w = '{op: OP_NOP,    cond: C_NEVER,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* sv/mbdd_sequencer.sv */
// Microcode sequencer: step counter, control store lookup, branch logic.
module mbdd_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_busy_i,
  input  mbdd_pkg::status_t   status_i,
  output mbdd_pkg::ctrl_t     ctrl_o
);

  logic [mbdd_pkg::PC_W-1:0] pc_q, pc_d;
  mbdd_pkg::uword_t          uw;
  logic                      take;

  assign uw = mbdd_pkg::ucode_word(pc_q);

  always_comb begin
    case (uw.cond)
      mbdd_pkg::C_NEVER:    take = 1'b0;
      mbdd_pkg::C_NO_INPUT: take = !in_valid_i;
      mbdd_pkg::C_DZ:       take = status_i.dz;
      mbdd_pkg::C_LT:       take = status_i.lt;
      mbdd_pkg::C_MORE:     take = status_i.more;
      mbdd_pkg::C_OUT_BUSY: take = out_busy_i;
      default:              take = 1'b0;
    endcase
  end

  assign pc_d = take ? uw.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mbdd_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // go qualifies the handshake steps
  always_comb begin
    ctrl_o.op = uw.op;
    case (uw.op)
      mbdd_pkg::OP_ACCEPT: ctrl_o.go = in_valid_i;
      mbdd_pkg::OP_EMIT:   ctrl_o.go = !out_busy_i;
      default:             ctrl_o.go = 1'b1;
    endcase
  end

endmodule

/* sv/mbdd_datapath.sv */
// Shift-subtract datapath: partial remainder, digit and quotient shifter.
module mbdd_datapath #(
  parameter int unsigned DW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbdd_pkg::ctrl_t     ctrl_i,
  input  mbdd_pkg::in_word_t  in_word_i,
  input  logic [DW-1:0]       div_i,
  output mbdd_pkg::status_t   status_o,
  output mbdd_pkg::out_word_t res_o
);

  localparam int unsigned CW    = $clog2(DW);
  localparam int unsigned WordW = mbdd_pkg::WORD_W;

  logic [DW-1:0] rem_q, rem_d;   // partial remainder, kept across digits
  logic [DW-1:0] dig_q, dig_d;
  logic [DW-1:0] sh_q, sh_d;     // dividend bits out, quotient bits in
  logic [CW-1:0] cnt_q, cnt_d;
  logic          last_q, last_d;
  logic [DW:0]   trial, diff;
  logic          ge, dz;

  assign dz    = (div_i == '0);
  assign trial = {rem_q, sh_q[DW-1]};
  assign diff  = trial - {1'b0, div_i};
  // remainder stays below the divisor, so the top bit is the borrow
  assign ge    = !diff[DW];

  always_comb begin
    rem_d  = rem_q;
    dig_d  = dig_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    case (ctrl_i.op)
      mbdd_pkg::OP_ACCEPT: begin
        if (ctrl_i.go) begin
          dig_d  = in_word_i.dividend_digit[DW-1:0];
          last_d = in_word_i.final_digit;
        end
      end
      mbdd_pkg::OP_PRE: begin
        // stale remainder not below divisor: reduce it first
        sh_d  = rem_q;
        rem_d = '0;
        cnt_d = '0;
      end
      mbdd_pkg::OP_DIG: begin
        sh_d  = dig_q;
        cnt_d = '0;
      end
      mbdd_pkg::OP_ITER: begin
        rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
        sh_d  = {sh_q[DW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
      mbdd_pkg::OP_EMIT: begin
        if (ctrl_i.go && (last_q || dz)) begin
          rem_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  assign status_o.dz   = dz;
  assign status_o.lt   = (rem_q < div_i);
  assign status_o.more = (cnt_q != CW'(DW - 1));

  assign res_o.quotient_digit = dz ? '0 : WordW'(sh_q);
  assign res_o.remainder_out  = (last_q && !dz) ? WordW'(rem_q) : '0;
  assign res_o.end_of_number  = last_q;
  assign res_o.divide_by_zero = dz;

endmodule

/* sv/multiword_by_digit_divider_unit.sv */
// Top level of the multiword by single digit divider.
//
// Short division of a long unsigned number by one digit. Dividend digits
// arrive most significant first, one per input word; final_digit marks the
// least significant one. Each input word gives exactly one output word with
// the quotient digit of the same position; the word for the final digit also
// carries the remainder of the whole number, after which the running
// remainder is cleared for the next number. The divisor comes from a single
// configuration register (reset 1), written with cfg_we_i; write it only
// while no word is in flight. A zero divisor flags
// divide_by_zero, returns zero digits and clears the running remainder.
// Only the low DIGIT_WIDTH bits of digits and divisor are used.
//
// Timing: one digit at a time. A small microcoded sequencer runs a
// restoring shift-subtract loop that makes one quotient bit per cycle.
// After a digit is accepted it checks the divisor for zero, compares the
// kept remainder with the divisor, loads the digit into the shifter, runs
// the loop over all DIGIT_WIDTH bits and loads the output word, and only
// then takes the next digit. If the divisor was changed in the middle of a
// number and the kept remainder is not below it, an extra reduction pass
// runs first. A zero divisor skips the loop and goes straight to the output
// word. The output word sits in a register, so the next digit is taken
// while an earlier result still waits for out_ready_i; a finished digit
// holds in its last step while the previous word is still unread.
`include "multiword_by_digit_divider_unit_assert.svh"

module multiword_by_digit_divider_unit #(
  parameter int unsigned DIGIT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // digit input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mbdd_pkg::in_word_t  in_word_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbdd_pkg::out_word_t out_word_o,
  // divisor register
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);

  logic [DIGIT_WIDTH-1:0] div_q;
  logic                   out_valid_q;
  mbdd_pkg::out_word_t    out_word_q;
  mbdd_pkg::ctrl_t        ctrl;
  mbdd_pkg::status_t      status;
  mbdd_pkg::out_word_t    res;
  logic                   out_busy;
  logic                   out_load;

  // divisor register, low bits only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= DIGIT_WIDTH'(1);
    end else if (cfg_we_i) begin
      div_q <= cfg_wdata_i[DIGIT_WIDTH-1:0];
    end
  end

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (ctrl.op == mbdd_pkg::OP_EMIT) && ctrl.go;

  mbdd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mbdd_datapath #(
    .DW (DIGIT_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_word_i (in_word_i),
    .div_i     (div_q),
    .status_o  (status),
    .res_o     (res)
  );

  assign in_ready_o = (ctrl.op == mbdd_pkg::OP_ACCEPT);

  // output register; loads only when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // one digit in flight: no accept right after an accept
  `MBDD_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  // remainder only reported with the final digit
  `MBDD_ASSERT_NEVER(a_rem_only_final, clk_i, rst_ni, out_valid_o && !out_word_o.end_of_number && (out_word_o.remainder_out != '0))
  // zero flag tracks the divisor used for the word
  `MBDD_ASSERT(a_dz_flag, clk_i, rst_ni, out_load |=> out_word_o.divide_by_zero == $past(div_q == '0))

endmodule
